[design/lru_page_replacement_list_defines.svh]
// Assertion macros shared by the modules of the recency list.
`ifndef LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define LRU_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lru_pkg.sv]
package lru_pkg;

   localparam int ENTRIES        = 8;
   localparam int PAGE_BITS      = 20;
   localparam int PAGE_ID_W      = 20;
   localparam int ENTRIES_HELD_W = 4;
   localparam int CNT_W          = $clog2(ENTRIES + 1);
   localparam int IDX_W          = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_TOUCH  = 2'd1,
      CMD_EVICT  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMPARE
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
   } ctl_type;

endpackage

[design/lru_page_replacement_list.sv]
// Recency list of up to ENTRIES page numbers, most recent first. Each request
// passes through two states: ST_IDLE captures the command and page, and in
// ST_COMPARE all entries are compared in parallel, the entry chain shifts to
// bring an inserted or touched page to the front, and the result register is
// loaded. The next request is taken while that result still waits on
// rsp_ready; a request stalls in ST_COMPARE until the previous result is taken.
module lru_page_replacement_list
   import lru_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [PAGE_ID_W-1:0]      req_page_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PAGE_ID_W-1:0]      rsp_victim_page,
   output logic                      rsp_victim_valid,
   output logic                      rsp_page_found,
   output logic                      rsp_list_full_drop,
   output logic [ENTRIES_HELD_W-1:0] rsp_entries_held
);

   ctl_type ctl;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   lru_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_command        (req_command),
      .req_page_id        (req_page_id),
      .rsp_victim_page    (rsp_victim_page),
      .rsp_victim_valid   (rsp_victim_valid),
      .rsp_page_found     (rsp_page_found),
      .rsp_list_full_drop (rsp_list_full_drop),
      .rsp_entries_held   (rsp_entries_held)
   );

endmodule

[design/lru_ctrl.sv]
`include "lru_page_replacement_list_defines.svh"

module lru_ctrl
   import lru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      ctl.load     = 1'b0;
      ctl.update   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `LRU_ASSERT_NEXT(a_update_shows_rsp, ctl.update, rsp_valid_ff, "Update did not raise rsp_valid.")
   `LRU_ASSERT(a_no_overwrite, !(ctl.update && rsp_valid_ff && !rsp_ready), "Result overwritten.")
   `LRU_ASSERT_NEXT(a_load_then_compare, ctl.load, state_ff == ST_COMPARE, "Load left no compare.")

endmodule

[design/lru_dpath.sv]
`include "lru_page_replacement_list_defines.svh"

module lru_dpath
   import lru_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   input  logic [1:0]                req_command,
   input  logic [PAGE_ID_W-1:0]      req_page_id,
   output logic [PAGE_ID_W-1:0]      rsp_victim_page,
   output logic                      rsp_victim_valid,
   output logic                      rsp_page_found,
   output logic                      rsp_list_full_drop,
   output logic [ENTRIES_HELD_W-1:0] rsp_entries_held
);

   logic [PAGE_BITS-1:0]      cells_ff [ENTRIES];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   cmd_type                   cmd_ff;
   logic [PAGE_BITS-1:0]      page_ff;
   logic [ENTRIES-1:0]        match;
   logic [ENTRIES-1:0]        shift_en;
   logic                      found;
   logic                      full;
   logic                      ins_new;
   logic                      evict_ok;
   logic [CNT_W-1:0]          last_pos;
   logic [PAGE_BITS-1:0]      victim;
   logic [PAGE_ID_W-1:0]      victim_page_ff;
   logic                      victim_valid_ff;
   logic                      page_found_ff;
   logic                      drop_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= cmd_type'(req_command);
         page_ff <= PAGE_BITS'(req_page_id);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (cells_ff[i] == page_ff) &&
                    ((cmd_ff == CMD_INSERT) || (cmd_ff == CMD_TOUCH));
      end
   end

   assign found    = |match;
   assign full     = (count_ff == CNT_W'(ENTRIES));
   assign ins_new  = (cmd_ff == CMD_INSERT) && !found && !full;
   assign evict_ok = (cmd_ff == CMD_EVICT) && (count_ff != '0);
   assign last_pos = count_ff - CNT_W'(1);
   assign victim   = cells_ff[last_pos[IDX_W-1:0]];

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         shift_en[i] = 1'b0;
         for (int j = i; j < ENTRIES; j++) begin
            shift_en[i] = shift_en[i] | match[j];
         end
         if (ins_new && (CNT_W'(i) <= count_ff)) begin
            shift_en[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         for (int i = 1; i < ENTRIES; i++) begin
            if (shift_en[i]) begin
               cells_ff[i] <= cells_ff[i-1];
            end
         end
         if (shift_en[0]) begin
            cells_ff[0] <= page_ff;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.update) begin
         if (ins_new) begin
            count_in = count_ff + CNT_W'(1);
         end else if (evict_ok) begin
            count_in = last_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         victim_page_ff  <= evict_ok ? PAGE_ID_W'(victim) : '0;
         victim_valid_ff <= evict_ok;
         page_found_ff   <= found;
         drop_ff         <= (cmd_ff == CMD_INSERT) && !found && full;
      end
   end

   assign rsp_victim_page    = victim_page_ff;
   assign rsp_victim_valid   = victim_valid_ff;
   assign rsp_page_found     = page_found_ff;
   assign rsp_list_full_drop = drop_ff;
   assign rsp_entries_held   = ENTRIES_HELD_W'(count_ff);

   `LRU_ASSERT(a_match_unique, $onehot0(match), "Page listed more than once.")
   `LRU_ASSERT(a_count_bound, count_ff <= CNT_W'(ENTRIES), "Entry count above capacity.")
   `LRU_ASSERT_NEXT(a_evict_dec, ctl.update && evict_ok, count_ff == $past(last_pos), "Evict miscounted.")

endmodule

[verif/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lru_pkg::*;

   typedef struct packed {
      logic [PAGE_ID_W-1:0]      victim_page;
      logic                      victim_valid;
      logic                      page_found;
      logic                      list_full_drop;
      logic [ENTRIES_HELD_W-1:0] entries_held;
   } lru_result_type;

   class recency_scoreboard;
      logic [PAGE_BITS-1:0] recency[ENTRIES];
      int unsigned          held;
      lru_result_type       expected_outcomes[$];
      int unsigned          mismatches;
      int unsigned          responses_checked;
      int unsigned          command_tally[4];
      int unsigned          hits;
      int unsigned          drops;
      int unsigned          victims;
      int unsigned          empty_evicts;
      int unsigned          peak_held;

      function new();
         held = 0;
         mismatches = 0;
         responses_checked = 0;
         hits = 0;
         drops = 0;
         victims = 0;
         empty_evicts = 0;
         peak_held = 0;
         foreach (command_tally[i]) command_tally[i] = 0;
      endfunction

      function int unsigned pending();
         return expected_outcomes.size();
      endfunction

      function void bring_to_front(int pos);
         logic [PAGE_BITS-1:0] moved;
         moved = recency[pos];
         for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
         recency[0] = moved;
      endfunction

      function lru_result_type predict_outcome(cmd_type cmd, logic [PAGE_ID_W-1:0] page_in);
         lru_result_type       r;
         logic [PAGE_BITS-1:0] page;
         int                   pos;
         r = '0;
         page = page_in[PAGE_BITS-1:0];
         pos = -1;
         case (cmd)
            CMD_INSERT, CMD_TOUCH: begin
               for (int i = 0; i < held; i++) begin
                  if (pos < 0 && recency[i] == page) pos = i;
               end
               if (pos >= 0) begin
                  r.page_found = 1'b1;
                  bring_to_front(pos);
                  hits++;
               end else if (cmd == CMD_INSERT) begin
                  if (held < ENTRIES) begin
                     recency[held] = page;
                     held++;
                     bring_to_front(held - 1);
                  end else begin
                     r.list_full_drop = 1'b1;
                     drops++;
                  end
               end
            end
            CMD_EVICT: begin
               if (held > 0) begin
                  held--;
                  r.victim_page = recency[held];
                  r.victim_valid = 1'b1;
                  victims++;
               end else begin
                  empty_evicts++;
               end
            end
            default: begin
            end
         endcase
         r.entries_held = held[ENTRIES_HELD_W-1:0];
         if (held > peak_held) peak_held = held;
         return r;
      endfunction

      function void note_request(cmd_type cmd, logic [PAGE_ID_W-1:0] page);
         command_tally[cmd]++;
         expected_outcomes.push_back(predict_outcome(cmd, page));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 50) $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_response(lru_result_type got);
         lru_result_type want;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
            return;
         end
         want = expected_outcomes.pop_front();
         responses_checked++;
         if (got.victim_page !== want.victim_page)
            report_mismatch($sformatf("victim_page got %h expected %h",
                                      got.victim_page, want.victim_page));
         if (got.victim_valid !== want.victim_valid)
            report_mismatch($sformatf("victim_valid got %b expected %b",
                                      got.victim_valid, want.victim_valid));
         if (got.page_found !== want.page_found)
            report_mismatch($sformatf("page_found got %b expected %b",
                                      got.page_found, want.page_found));
         if (got.list_full_drop !== want.list_full_drop)
            report_mismatch($sformatf("list_full_drop got %b expected %b",
                                      got.list_full_drop, want.list_full_drop));
         if (got.entries_held !== want.entries_held)
            report_mismatch($sformatf("entries_held got %0d expected %0d",
                                      got.entries_held, want.entries_held));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_command = CMD_INSERT;
   logic [PAGE_ID_W-1:0]      req_page_id = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PAGE_ID_W-1:0]      rsp_victim_page;
   logic                      rsp_victim_valid;
   logic                      rsp_page_found;
   logic                      rsp_list_full_drop;
   logic [ENTRIES_HELD_W-1:0] rsp_entries_held;

   lru_result_type    observed;
   recency_scoreboard scoreboard = new();
   int unsigned       sender_gap_pct = 34;
   int unsigned       receiver_stall_pct = 66;
   logic [PAGE_ID_W-1:0] page_pool[16];

   lru_page_replacement_list uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_page_id        (req_page_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_victim_page    (rsp_victim_page),
      .rsp_victim_valid   (rsp_victim_valid),
      .rsp_page_found     (rsp_page_found),
      .rsp_list_full_drop (rsp_list_full_drop),
      .rsp_entries_held   (rsp_entries_held)
   );

   always #5 clock = ~clock;

   assign observed = {rsp_victim_page, rsp_victim_valid, rsp_page_found,
                      rsp_list_full_drop, rsp_entries_held};

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scoreboard.note_request(cmd_type'(req_command), req_page_id);
         if (rsp_valid && rsp_ready) scoreboard.check_response(observed);
      end
   end

   task automatic send_request(cmd_type cmd, logic [PAGE_ID_W-1:0] page);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_page_id <= page;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(CMD_EVICT, 20'h00000);
      send_request(CMD_TOUCH, 20'h00000);
      send_request(CMD_NONE,  20'hFFFFF);
      send_request(CMD_INSERT, 20'h00000);
      send_request(CMD_INSERT, 20'hFFFFF);
      send_request(CMD_INSERT, 20'hFFFFF);
      send_request(CMD_INSERT, 20'h00000);
      send_request(CMD_INSERT, 20'h00001);
      send_request(CMD_INSERT, 20'h80000);
      send_request(CMD_INSERT, 20'h55555);
      send_request(CMD_INSERT, 20'hAAAAA);
      send_request(CMD_INSERT, 20'h00002);
      send_request(CMD_INSERT, 20'h7FFFF);
      send_request(CMD_INSERT, 20'h12345);
      send_request(CMD_INSERT, 20'hFFFFF);
      send_request(CMD_TOUCH, 20'h00777);
      send_request(CMD_TOUCH, 20'hFFFFF);
      send_request(CMD_TOUCH, 20'h55555);
      send_request(CMD_NONE,  20'h00000);
      repeat (ENTRIES + 1) send_request(CMD_EVICT, 20'hFFFFF);
   endtask

   task automatic run_random_phase(int count, int gap_pct, int stall_pct);
      int unsigned          roll;
      int unsigned          mode;
      int unsigned          insert_pct;
      int unsigned          touch_pct;
      cmd_type              cmd;
      logic [PAGE_ID_W-1:0] page;
      sender_gap_pct = gap_pct;
      receiver_stall_pct = stall_pct;
      foreach (page_pool[i]) page_pool[i] = PAGE_ID_W'($urandom);
      mode = 0;
      insert_pct = 40;
      touch_pct = 30;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            mode = $urandom_range(2);
            insert_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
            touch_pct = 25;
         end
         roll = $urandom_range(99);
         if (roll < 2) cmd = CMD_NONE;
         else if (roll < 2 + insert_pct) cmd = CMD_INSERT;
         else if (roll < 2 + insert_pct + touch_pct) cmd = CMD_TOUCH;
         else cmd = CMD_EVICT;
         if ($urandom_range(99) < 85) page = page_pool[$urandom_range(15)];
         else page = PAGE_ID_W'($urandom);
         send_request(cmd, page);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      wait_drained();
      run_random_phase(270, 34, 66);
      wait_drained();
      run_random_phase(270, 66, 34);
      wait_drained();
      run_random_phase(260, 0, 0);
      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && scoreboard.pending() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.pending() != 0)
         scoreboard.report_mismatch($sformatf("%0d expected responses never arrived",
                                              scoreboard.pending()));
      $display("Covered %0d inserts, %0d touches, %0d evicts, %0d unused codes; %0d responses.",
               scoreboard.command_tally[CMD_INSERT], scoreboard.command_tally[CMD_TOUCH],
               scoreboard.command_tally[CMD_EVICT], scoreboard.command_tally[CMD_NONE],
               scoreboard.responses_checked);
      $display("Hits %0d, full-list drops %0d, victims %0d, empty evicts %0d, peak held %0d.",
               scoreboard.hits, scoreboard.drops, scoreboard.victims,
               scoreboard.empty_evicts, scoreboard.peak_held);
      if (scoreboard.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
